FILE: sv/inverse_trig_unit_top_macros.svh
// Assertion macros for the inverse trig unit.
// Included by inverse_trig_unit_top.sv; expects clk and rst in scope.
`ifndef INVERSE_TRIG_UNIT_TOP_MACROS_SVH
`define INVERSE_TRIG_UNIT_TOP_MACROS_SVH

`ifndef SYNTHESIS
// implication property checked on every clock outside reset
`define ITU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// condition that must never be seen outside reset
`define ITU_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ITU_ASSERT_IMPL(label, ante, cons, msg)
`define ITU_ASSERT_NEVER(label, cond, msg)
`endif

`endif

FILE: sv/itu_pkg.sv
// Shared types, constants and elaboration-time table functions for the
// inverse trig unit. No dependencies.
package itu_pkg;

  localparam int ITERATIONS_DEF = 28;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int MAX_STAGES     = 40;
  localparam int ANG_FRAC       = 60;
  localparam int CW             = 42;  // CORDIC x/y width
  localparam int ZW             = 64;  // angle accumulator width
  localparam int SQRT_BITS      = 31;

  localparam logic [63:0] PI4_Q60 = 64'h0C90FDAA22168C23;

  typedef enum logic [1:0] {
    FN_ASIN       = 2'd0,
    FN_ACOS       = 2'd1,
    FN_ATAN       = 2'd2,
    FN_ATAN_RECIP = 2'd3
  } fn_sel_t;

  // sideband that travels with each transaction
  typedef struct packed {
    logic    valid;
    fn_sel_t fsel;
    logic    err;
    logic    x_neg;
    logic    y_zero;
  } itu_tag_t;

  // shift-subtract division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      q = {q[62:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) with 60 fractional bits, odd power series, each term truncated
  function automatic logic [63:0] atan_tab(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    logic        add;
    sum = '0;
    add = 1'b1;
    if (i == 0) begin
      sum = PI4_Q60;
    end else begin
      for (int k = 1; k <= ANG_FRAC; k += 2) begin
        if (k * i <= ANG_FRAC) begin
          term = udiv64(64'd1 << (ANG_FRAC - k * i), 64'(k));
          sum  = add ? sum + term : sum - term;
          add  = !add;
        end
      end
    end
    return sum;
  endfunction

  // floor(180 * 2^95 / (pi with 55 fractional bits)): 180/pi with 40 frac bits
  function automatic logic [63:0] deg_factor();
    logic [103:0] num;
    logic [63:0]  d;
    logic [63:0]  r;
    logic [103:0] q;
    num = 104'd180 << 95;
    d   = PI4_Q60 >> 3;
    r   = '0;
    q   = '0;
    for (int b = 103; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      q = {q[102:0], 1'b0};
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q[63:0];
  endfunction

endpackage

FILE: sv/itu_cordic.sv
// Vectoring CORDIC pipeline, one micro-rotation per register stage.
// Depends on itu_pkg (widths, tag type, arctangent table).
module itu_cordic #(
  parameter int STAGES = itu_pkg::ITERATIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  itu_pkg::itu_tag_t             in_tag,
  input  logic signed [itu_pkg::CW-1:0] in_x,
  input  logic signed [itu_pkg::CW-1:0] in_y,
  output itu_pkg::itu_tag_t             out_tag,
  output logic signed [itu_pkg::ZW-1:0] out_z
);
  import itu_pkg::*;

  itu_tag_t           tag [0:STAGES];
  logic signed [CW-1:0] xr [0:STAGES];
  logic signed [CW-1:0] yr [0:STAGES];
  logic signed [ZW-1:0] zr [0:STAGES];

  assign tag[0] = in_tag;
  assign xr[0]  = in_x;
  assign yr[0]  = in_y;
  assign zr[0]  = '0;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic [63:0] TAB = atan_tab(i);
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    assign xs = xr[i] >>> i;
    assign ys = yr[i] >>> i;

    // rotate toward y = 0
    always_ff @(posedge clk) begin
      if (rst) begin
        tag[i+1].valid <= 1'b0;
      end else begin
        tag[i+1] <= tag[i];
      end
      if (!yr[i][CW-1]) begin
        xr[i+1] <= xr[i] + ys;
        yr[i+1] <= yr[i] - xs;
        zr[i+1] <= zr[i] + $signed(TAB);
      end else begin
        xr[i+1] <= xr[i] - ys;
        yr[i+1] <= yr[i] + xs;
        zr[i+1] <= zr[i] - $signed(TAB);
      end
    end
  end

  assign out_tag = tag[STAGES];
  assign out_z   = zr[STAGES];

endmodule

FILE: sv/inverse_trig_unit_top.sv
// Inverse trig unit top: input saturation, root pipeline, CORDIC, scaling.
// Depends on itu_pkg, itu_cordic and inverse_trig_unit_top_macros.svh.
//
//  channel  | signals                                          | handshake
//  ---------+--------------------------------------------------+-----------------
//  command  | start, busy, operand                             | start & !busy
//  result   | done, angle_radians, angle_degrees, domain_error | done, one cycle
//  config   | cfg_we, cfg_wdata (function_select)              | cfg_we
//
// Fully pipelined: one transaction per cycle, results in order.
// Register stages: 2 input stages, 31 root stages (one result bit each), one
// CORDIC stage per iteration (at most MAX_STAGES), 4 output stages.
// busy is high only during reset; rst clears all valid bits and function_select.
// The receiver cannot stall, so the pipeline always advances.
module inverse_trig_unit_top #(
  parameter int ITERATIONS = itu_pkg::ITERATIONS_DEF,
  parameter int DATA_WIDTH = itu_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] operand,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_wdata,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] angle_radians,
  output logic signed [DATA_WIDTH-1:0] angle_degrees,
  output logic                         domain_error
);
  import itu_pkg::*;

  `include "inverse_trig_unit_top_macros.svh"

  localparam int NSTG = (ITERATIONS > MAX_STAGES) ? MAX_STAGES : ITERATIONS;
  localparam logic signed [64:0] XMAX = 65'sd2147483647;
  localparam logic signed [64:0] XMIN = -65'sd2147483648;
  localparam logic signed [64:0] WMAX = (65'sd1 <<< (DATA_WIDTH - 1)) - 65'sd1;
  localparam logic signed [64:0] WMIN = -WMAX - 65'sd1;
  localparam logic signed [ZW-1:0] PI2 = $signed(PI4_Q60 << 1);
  localparam logic [63:0] DEG_F_FULL = deg_factor();
  localparam logic [45:0] DEG_F = DEG_F_FULL[45:0];

  function automatic logic [DATA_WIDTH-1:0] to_word(input logic signed [64:0] v);
    logic [DATA_WIDTH-1:0] w;
    if (v > WMAX) w = WMAX[DATA_WIDTH-1:0];
    else if (v < WMIN) w = WMIN[DATA_WIDTH-1:0];
    else w = v[DATA_WIDTH-1:0];
    return w;
  endfunction

  fn_sel_t function_select;
  logic    accept;

  assign busy   = rst;
  assign accept = start && !busy;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      function_select <= FN_ASIN;
    end else if (cfg_we) begin
      function_select <= fn_sel_t'(cfg_wdata);
    end
  end

  // input saturation and domain check
  logic signed [64:0] op_ext;
  logic signed [31:0] x_sat;
  logic [32:0]        ax_in;
  logic               root_fn;

  assign op_ext  = {{(65 - DATA_WIDTH){operand[DATA_WIDTH-1]}}, operand};
  assign x_sat   = (op_ext > XMAX) ? 32'sh7FFFFFFF :
                   (op_ext < XMIN) ? 32'sh80000000 : op_ext[31:0];
  assign ax_in   = x_sat[31] ? -{x_sat[31], x_sat} : {1'b0, x_sat};
  assign root_fn = (function_select == FN_ASIN) || (function_select == FN_ACOS);

  itu_tag_t           s0_tag;
  logic signed [31:0] s0_x;
  logic [24:0]        s0_ax;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_tag.valid <= 1'b0;
    end else begin
      s0_tag.valid <= accept;
    end
    s0_tag.fsel   <= function_select;
    s0_tag.err    <= root_fn && (ax_in > 33'd16777216);
    s0_tag.x_neg  <= x_sat[31];
    s0_tag.y_zero <= (x_sat == 32'sd0);
    s0_x          <= x_sat;
    s0_ax         <= ax_in[24:0];
  end

  // radicand (2^48 - x^2) << 14
  logic [49:0]        sq;
  logic [63:0]        rad_full;
  itu_tag_t           s1_tag;
  logic signed [31:0] s1_x;
  logic [61:0]        s1_rad;

  assign sq       = 50'(s0_ax) * 50'(s0_ax);
  assign rad_full = ((64'd1 << 48) - 64'(sq)) << 14;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag.valid <= 1'b0;
    end else begin
      s1_tag <= s0_tag;
    end
    s1_x   <= s0_x;
    s1_rad <= rad_full[61:0];
  end

  // square root, one result bit per stage, MSB first
  itu_tag_t           sr_tag  [0:SQRT_BITS];
  logic signed [31:0] sr_x    [0:SQRT_BITS];
  logic [61:0]        sr_rem  [0:SQRT_BITS];
  logic [30:0]        sr_root [0:SQRT_BITS];

  assign sr_tag[0]  = s1_tag;
  assign sr_x[0]    = s1_x;
  assign sr_rem[0]  = s1_rad;
  assign sr_root[0] = '0;

  for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
    localparam int B = SQRT_BITS - 1 - j;
    logic [63:0] trial;
    logic        take;

    assign trial = ({33'd0, sr_root[j]} << (B + 1)) + (64'd1 << (2 * B));
    assign take  = {2'b00, sr_rem[j]} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sr_tag[j+1].valid <= 1'b0;
      end else begin
        sr_tag[j+1] <= sr_tag[j];
      end
      sr_x[j+1]    <= sr_x[j];
      sr_rem[j+1]  <= take ? sr_rem[j] - trial[61:0] : sr_rem[j];
      sr_root[j+1] <= take ? (sr_root[j] | (31'd1 << B)) : sr_root[j];
    end
  end

  // CORDIC input vector
  logic signed [CW-1:0] cx0;
  logic signed [CW-1:0] cy0;
  itu_tag_t             c_tag;
  logic signed [ZW-1:0] c_z;
  logic                 sq_root_fn;

  assign sq_root_fn = (sr_tag[SQRT_BITS].fsel == FN_ASIN) ||
                      (sr_tag[SQRT_BITS].fsel == FN_ACOS);
  assign cx0 = sq_root_fn ? $signed({{(CW - SQRT_BITS){1'b0}}, sr_root[SQRT_BITS]})
                          : $signed(CW'(64'd2147483648));
  assign cy0 = $signed({{(CW - 39){sr_x[SQRT_BITS][31]}}, sr_x[SQRT_BITS], 7'd0});

  itu_cordic #(.STAGES(NSTG)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (sr_tag[SQRT_BITS]),
    .in_x    (cx0),
    .in_y    (cy0),
    .out_tag (c_tag),
    .out_z   (c_z)
  );

  // function select adjustment
  logic signed [ZW-1:0] zc;
  logic signed [ZW-1:0] z_adj;
  itu_tag_t             pa_tag;
  logic signed [ZW-1:0] pa_z;

  assign zc = c_tag.y_zero ? '0 : c_z;

  always_comb begin
    case (c_tag.fsel)
      FN_ACOS:       z_adj = PI2 - zc;
      FN_ATAN_RECIP: z_adj = (c_tag.x_neg ? -PI2 : PI2) - zc;
      default:       z_adj = zc;
    endcase
    if (c_tag.err) begin
      z_adj = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pa_tag.valid <= 1'b0;
    end else begin
      pa_tag <= c_tag;
    end
    pa_z <= z_adj;
  end

  // magnitude and rounding to radians and Q40
  logic [63:0] mag;
  logic [63:0] rad_sum;
  logic [63:0] m40_sum;
  itu_tag_t    mg_tag;
  logic [31:0] mg_rad;
  logic [42:0] mg_m40;
  logic        mg_neg;

  assign mag     = pa_z[ZW-1] ? 64'(-pa_z) : 64'(pa_z);
  assign rad_sum = mag + (64'd1 << 30);
  assign m40_sum = mag + (64'd1 << 19);

  always_ff @(posedge clk) begin
    if (rst) begin
      mg_tag.valid <= 1'b0;
    end else begin
      mg_tag <= pa_tag;
    end
    mg_rad <= rad_sum[62:31];
    mg_m40 <= m40_sum[62:20];
    mg_neg <= pa_z[ZW-1];
  end

  // degree partial products
  itu_tag_t    pp_tag;
  logic [31:0] pp_rad;
  logic        pp_neg;
  logic [44:0] pp_hh;
  logic [44:0] pp_hl;
  logic [43:0] pp_lh;
  logic [43:0] pp_ll;

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_tag.valid <= 1'b0;
    end else begin
      pp_tag <= mg_tag;
    end
    pp_rad <= mg_rad;
    pp_neg <= mg_neg;
    pp_hh  <= 45'(mg_m40[42:21]) * 45'(DEG_F[45:23]);
    pp_hl  <= 45'(mg_m40[42:21]) * 45'(DEG_F[22:0]);
    pp_lh  <= 44'(mg_m40[20:0]) * 44'(DEG_F[45:23]);
    pp_ll  <= 44'(mg_m40[20:0]) * 44'(DEG_F[22:0]);
  end

  // sum, round, sign and saturate
  logic [89:0]        prod;
  logic [32:0]        deg_mag;
  logic signed [64:0] rad_s;
  logic signed [64:0] deg_s;

  assign prod    = (90'(pp_hh) << 44) + (90'(pp_hl) << 21) + (90'(pp_lh) << 23)
                 + 90'(pp_ll) + (90'd1 << 56);
  assign deg_mag = prod[89:57];
  assign rad_s   = pp_neg ? -$signed({33'd0, pp_rad}) : $signed({33'd0, pp_rad});
  assign deg_s   = pp_neg ? -$signed({32'd0, deg_mag}) : $signed({32'd0, deg_mag});

  always_ff @(posedge clk) begin
    if (rst) begin
      done         <= 1'b0;
      domain_error <= 1'b0;
    end else begin
      done         <= pp_tag.valid;
      domain_error <= pp_tag.valid && pp_tag.err;
    end
    angle_radians <= to_word(rad_s);
    angle_degrees <= to_word(deg_s);
  end

  // checks
  `ITU_ASSERT_NEVER(a_err_strobe, domain_error && !done, "domain_error without done")
  `ITU_ASSERT_IMPL(a_err_zero, done && domain_error,
                   angle_radians == '0 && angle_degrees == '0, "nonzero angle on domain error")
  `ITU_ASSERT_IMPL(a_sign_match, done && angle_radians[DATA_WIDTH-1],
                   angle_degrees[DATA_WIDTH-1] || angle_degrees == '0,
                   "positive degrees with negative radians")
  `ITU_ASSERT_IMPL(a_err_fn, pa_tag.valid && pa_tag.err,
                   pa_z == '0 && (pa_tag.fsel == FN_ASIN || pa_tag.fsel == FN_ACOS),
                   "domain error outside asin/acos")

endmodule
